// ----- src/dho_pkg.sv -----
// ----------------------------------------------------------------------------
// dho_pkg
// Constants, cosine quarter-wave table and register codes for the
// decaying-harmonics oscillator.
// ----------------------------------------------------------------------------
package dho_pkg;

  localparam int COS_TABLE_DEPTH = 1024;
  localparam int LOG_STEPS       = 16;

  // table address covers 0..COS_TABLE_DEPTH inclusive
  localparam int TAB_AW = $clog2(COS_TABLE_DEPTH + 1);
  localparam int I_W    = $clog2(COS_TABLE_DEPTH);
  localparam int IDX_W  = I_W + 2;

  // shared divider: 62 numerator bits, 35 bit divisor
  localparam int DIV_N = 62;
  localparam int DIV_W = 35;
  localparam int CNT_W = 6;

  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
  localparam logic [31:0] FOURPI_Q28 = 32'd3373259426;
  localparam logic [29:0] LN2_Q30    = 30'd744261118;
  localparam logic [29:0] K_SCALE_Q30 = 30'd1069129368;
  localparam logic [29:0] K_PLAIN_Q30 = 30'd1073676288;
  localparam logic [29:0] WARP_ADD_Q30 = 30'd32768;

  typedef enum logic [2:0] {
    REG_OFFSET_LEVEL       = 3'd0,
    REG_AMPLITUDE          = 3'd1,
    REG_SCALE_MODE         = 3'd2,
    REG_FREQ_FROM_STREAM   = 3'd3,
    REG_FIXED_FREQ         = 3'd4,
    REG_BRIGHT_FROM_STREAM = 3'd5,
    REG_FIXED_BRIGHT       = 3'd6
  } reg_index_t;

  typedef logic [30:0] cos_tab_t [0:COS_TABLE_DEPTH];

  // quarter-wave cosine, Q1.30, 12-term series evaluated at elaboration
  function automatic cos_tab_t build_cos_tab();
    cos_tab_t          t;
    logic [63:0]       x;
    logic [63:0]       x2;
    logic [63:0]       term;
    logic signed [63:0] sum;
    for (int i = 0; i <= COS_TABLE_DEPTH; i++) begin
      x    = (HALFPI_Q30 * 64'(i)) / 64'(COS_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        if ((k % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > $signed(ONE_Q30)) sum = $signed(ONE_Q30);
      t[i] = sum[30:0];
    end
    return t;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ----- src/decaying_harmonics_oscillator_core.sv -----
// ----------------------------------------------------------------------------
// decaying_harmonics_oscillator_core
// Discrete-summation oscillator: one sample per request, computed by a
// sequencer around one shared 32x32 multiplier and one restoring divider.
// ----------------------------------------------------------------------------
// Flow: a zero frequency goes from accept straight to the done state. Otherwise
//   the sample takes two 62-step divider runs and the serial log, plus a
//   scaling multiply in scale mode; each log argument is normalised by 0..30 shifts.
// Throughput: one request at a time; in_ready only in idle. A finished sample
//   waits in idle's predecessor while the previous one is still unread.
// Reset: phase cleared, registers to defaults, output channel emptied.
// ----------------------------------------------------------------------------
module decaying_harmonics_oscillator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [30:0]        freq_sample,
  input  logic [15:0]        bright_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  typedef enum logic [28:0] {
    ST_IDLE  = 29'h0000_0001,
    ST_WARP  = 29'h0000_0002,
    ST_MSET  = 29'h0000_0004,
    ST_MSQ   = 29'h0000_0008,
    ST_M2SET = 29'h0000_0010,
    ST_DIVC  = 29'h0000_0020,
    ST_CSET  = 29'h0000_0040,
    ST_FM    = 29'h0000_0080,
    ST_FMSET = 29'h0000_0100,
    ST_DD    = 29'h0000_0200,
    ST_DDSET = 29'h0000_0400,
    ST_CRD0  = 29'h0000_0800,
    ST_CRD1  = 29'h0000_1000,
    ST_CMULB = 29'h0000_2000,
    ST_CSUM  = 29'h0000_4000,
    ST_CPR   = 29'h0000_8000,
    ST_CX    = 29'h0001_0000,
    ST_LNORM = 29'h0002_0000,
    ST_LSQ   = 29'h0004_0000,
    ST_LCHK  = 29'h0008_0000,
    ST_LDONE = 29'h0010_0000,
    ST_LN2   = 29'h0020_0000,
    ST_LSET  = 29'h0040_0000,
    ST_SCMUL = 29'h0080_0000,
    ST_SCSET = 29'h0100_0000,
    ST_DIVQ  = 29'h0200_0000,
    ST_QAMP  = 29'h0400_0000,
    ST_FIN   = 29'h0800_0000,
    ST_DONE  = 29'h1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic signed [15:0] offset_level;
  logic signed [15:0] amplitude;
  logic               scale_mode;
  logic               freq_from_stream;
  logic [30:0]        fixed_freq;
  logic               bright_from_stream;
  logic [15:0]        fixed_bright;

  // oscillator state and working registers
  logic [31:0] phase;
  logic [31:0] pn;
  logic [30:0] f;
  logic [15:0] b;
  logic [29:0] m;
  logic [29:0] m2;
  logic [29:0] c;
  logic [30:0] fm;
  logic [dho_pkg::DIV_W-1:0] dd;
  logic [46:0] acc;
  logic [30:0] mag;
  logic [30:0] x;
  logic [4:0]  s;
  logic [dho_pkg::LOG_STEPS-1:0] frac;
  logic signed [37:0] lnum;
  logic        sel_den;
  logic        dneg;
  logic [29:0] amag;
  logic [29:0] l;
  logic [dho_pkg::DIV_N-1:0] nq;
  logic [dho_pkg::DIV_W-1:0] rem;
  logic [dho_pkg::DIV_W-1:0] dvs;
  logic [dho_pkg::CNT_W-1:0] cnt;
  logic signed [15:0] res;
  logic [30:0] rom_data;
  logic [63:0] prod;

  // shared multiplier operands
  logic [31:0] opa;
  logic [31:0] opb;

  assign in_ready = (state == ST_IDLE);

  // request source selection
  logic [30:0] f_sel;
  logic [15:0] b_sel;
  assign f_sel = freq_from_stream   ? freq_sample   : fixed_freq;
  assign b_sel = bright_from_stream ? bright_sample : fixed_bright;

  // --- cosine table addressing -------------------------------------------
  // numerator uses the advanced phase, denominator the current one
  logic [31:0]                  cph;
  logic [dho_pkg::IDX_W-1:0]    idx;
  logic [15:0]                  f16;
  logic [1:0]                   quad;
  logic [dho_pkg::I_W-1:0]      ti;
  logic [dho_pkg::TAB_AW-1:0]   tj;
  logic [dho_pkg::TAB_AW-1:0]   addr0;
  logic [dho_pkg::TAB_AW-1:0]   addr1;
  logic [dho_pkg::TAB_AW-1:0]   rom_addr;
  logic                         cneg;

  assign cph   = sel_den ? phase : pn;
  assign idx   = cph[31 -: dho_pkg::IDX_W];
  assign f16   = cph[31 - dho_pkg::IDX_W -: 16];
  assign quad  = idx[dho_pkg::IDX_W-1 -: 2];
  assign ti    = idx[dho_pkg::I_W-1:0];
  assign tj    = dho_pkg::TAB_AW'(dho_pkg::COS_TABLE_DEPTH) - {1'b0, ti};
  // odd quadrants walk the table backwards
  assign addr0 = quad[0] ? tj : {1'b0, ti};
  assign addr1 = quad[0] ? (tj - 1'b1) : ({1'b0, ti} + 1'b1);
  assign cneg  = quad[1] ^ quad[0];
  assign rom_addr = (state == ST_CRD0) ? addr0 : addr1;

  always_ff @(posedge clk) begin
    rom_data <= dho_pkg::COS_TAB[rom_addr];
  end

  // --- shared multiplier ---------------------------------------------------
  logic [15:0] amp_mag;
  logic [31:0] qc;
  assign amp_mag = amplitude[15] ? 16'(-amplitude) : amplitude;
  // quotients past 32 bits saturate the output either way
  assign qc = (|nq[dho_pkg::DIV_N-1:32]) ? 32'hFFFF_FFFF : nq[31:0];

  always_comb begin
    opa = '0;
    opb = '0;
    case (state)
      ST_WARP: begin
        opa = {16'b0, b};
        opb = {2'b0, scale_mode ? dho_pkg::K_SCALE_Q30 : dho_pkg::K_PLAIN_Q30};
      end
      ST_MSQ: begin
        opa = {2'b0, m};
        opb = {2'b0, m};
      end
      ST_FM: begin
        opa = {1'b0, f};
        opb = {2'b0, m};
      end
      ST_DD: begin
        opa = {1'b0, fm};
        opb = dho_pkg::FOURPI_Q28;
      end
      ST_CRD1: begin
        opa = {1'b0, rom_data};
        opb = 32'(17'h1_0000 - {1'b0, f16});
      end
      ST_CMULB: begin
        opa = {1'b0, rom_data};
        opb = {16'b0, f16};
      end
      ST_CPR: begin
        opa = {2'b0, c};
        opb = {1'b0, mag};
      end
      ST_LSQ: begin
        opa = {1'b0, x};
        opb = {1'b0, x};
      end
      ST_LN2: begin
        opa = {2'b0, amag};
        opb = {2'b0, dho_pkg::LN2_Q30};
      end
      ST_SCMUL: begin
        opa = {2'b0, l};
        opb = 32'(31'h4000_0000 - {1'b0, m2});
      end
      ST_QAMP: begin
        opa = qc;
        opb = {16'b0, amp_mag};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {32'b0, opa} * {32'b0, opb};
  end

  // --- divider step: restoring, one quotient bit per cycle -----------------
  logic [dho_pkg::DIV_W:0]   rem_sh;
  logic                      q_bit;
  logic [dho_pkg::DIV_W:0]   rem_nx;
  assign rem_sh = {rem, nq[dho_pkg::DIV_N-1]};
  assign q_bit  = (rem_sh >= {1'b0, dvs});
  assign rem_nx = q_bit ? (rem_sh - {1'b0, dvs}) : rem_sh;

  // --- misc datapath terms -------------------------------------------------
  logic [29:0] pr;
  logic [30:0] xv;
  assign pr = prod[59:30];
  assign xv = cneg ? {1'b1, pr} : (31'h4000_0000 - {1'b0, pr});

  logic [31:0] ysq;
  assign ysq = prod[61:30];

  // log2 of the normalised argument: -shifts as integer, squared bits as fraction
  logic signed [5:0]  ip;
  logic [31:0]        fracf;
  logic signed [37:0] lval;
  logic signed [38:0] dv;
  logic [38:0]        dmag;
  assign ip    = -$signed({1'b0, s});
  assign fracf = 32'(frac) << (32 - dho_pkg::LOG_STEPS);
  assign lval  = {ip, fracf};
  assign dv    = $signed({lnum[37], lnum}) - $signed({lval[37], lval});
  assign dmag  = dv[38] ? 39'(-dv) : 39'(dv);

  // output gain, offset and clamp
  logic [36:0]        pv;
  logic signed [36:0] rs;
  logic signed [36:0] rsum;
  logic signed [15:0] rsat;
  assign pv   = {2'b0, prod[46:12]};
  assign rs   = (dneg ^ amplitude[15]) ? -$signed(pv) : $signed(pv);
  assign rsum = rs + 37'(offset_level);
  always_comb begin
    if (rsum > 37'sd32767) begin
      rsat = 16'sh7FFF;
    end else if (rsum < -37'sd32768) begin
      rsat = -16'sh8000;
    end else begin
      rsat = rsum[15:0];
    end
  end

  // --- sequencer -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_valid          <= 1'b0;
      phase              <= '0;
      offset_level       <= '0;
      amplitude          <= 16'sd4096;
      scale_mode         <= 1'b0;
      freq_from_stream   <= 1'b1;
      fixed_freq         <= '0;
      bright_from_stream <= 1'b0;
      fixed_bright       <= 16'h8000;
      sel_den            <= 1'b0;
      cnt                <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          dho_pkg::REG_OFFSET_LEVEL:       offset_level       <= cfg_data[15:0];
          dho_pkg::REG_AMPLITUDE:          amplitude          <= cfg_data[15:0];
          dho_pkg::REG_SCALE_MODE:         scale_mode         <= cfg_data[0];
          dho_pkg::REG_FREQ_FROM_STREAM:   freq_from_stream   <= cfg_data[0];
          dho_pkg::REG_FIXED_FREQ:         fixed_freq         <= cfg_data;
          dho_pkg::REG_BRIGHT_FROM_STREAM: bright_from_stream <= cfg_data[0];
          dho_pkg::REG_FIXED_BRIGHT:       fixed_bright       <= cfg_data[15:0];
          default: ;
        endcase
      end

      // a hand-over in the done state refills the output register instead
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (f_sel == '0) begin
              // silence: phase restarts, sample is the offset alone
              phase <= '0;
              res   <= offset_level;
              state <= ST_DONE;
            end else begin
              f       <= f_sel;
              b       <= b_sel;
              pn      <= phase + {1'b0, f_sel};
              sel_den <= 1'b0;
              state   <= ST_WARP;
            end
          end
        end
        ST_WARP:  state <= ST_MSET;
        ST_MSET: begin
          m     <= prod[45:16] + dho_pkg::WARP_ADD_Q30;
          state <= ST_MSQ;
        end
        ST_MSQ:   state <= ST_M2SET;
        ST_M2SET: begin
          // c = 2m / (1 + m^2)
          m2    <= prod[59:30];
          nq    <= {1'b0, m, 31'b0};
          dvs   <= {4'b0, 1'b1, prod[59:30]};
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIVC;
        end
        ST_DIVC: begin
          rem <= rem_nx[dho_pkg::DIV_W-1:0];
          nq  <= {nq[dho_pkg::DIV_N-2:0], q_bit};
          cnt <= cnt + 1'b1;
          if (cnt == dho_pkg::CNT_W'(dho_pkg::DIV_N - 1)) state <= ST_CSET;
        end
        ST_CSET: begin
          c     <= nq[29:0];
          state <= ST_FM;
        end
        ST_FM:    state <= ST_FMSET;
        ST_FMSET: begin
          fm    <= prod[60:30];
          state <= ST_DD;
        end
        ST_DD:    state <= ST_DDSET;
        ST_DDSET: begin
          // 4 pi f m, never zero
          dd    <= (prod[62:28] == '0) ? dho_pkg::DIV_W'(1) : prod[62:28];
          state <= ST_CRD0;
        end
        ST_CRD0:  state <= ST_CRD1;
        ST_CRD1:  state <= ST_CMULB;
        ST_CMULB: begin
          acc   <= prod[46:0];
          state <= ST_CSUM;
        end
        ST_CSUM: begin
          mag   <= 31'((48'(acc) + 48'(prod[46:0])) >> 16);
          state <= ST_CPR;
        end
        ST_CPR:   state <= ST_CX;
        ST_CX: begin
          x     <= (xv == '0) ? 31'd1 : xv;
          s     <= '0;
          state <= ST_LNORM;
        end
        ST_LNORM: begin
          if (x[30]) begin
            cnt   <= '0;
            state <= ST_LSQ;
          end else begin
            x <= {x[29:0], 1'b0};
            s <= s + 1'b1;
          end
        end
        ST_LSQ:   state <= ST_LCHK;
        ST_LCHK: begin
          if (ysq[31]) begin
            x    <= ysq[31:1];
            frac <= {frac[dho_pkg::LOG_STEPS-2:0], 1'b1};
          end else begin
            x    <= ysq[30:0];
            frac <= {frac[dho_pkg::LOG_STEPS-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == dho_pkg::CNT_W'(dho_pkg::LOG_STEPS - 1)) begin
            state <= ST_LDONE;
          end else begin
            state <= ST_LSQ;
          end
        end
        ST_LDONE: begin
          if (!sel_den) begin
            lnum    <= lval;
            sel_den <= 1'b1;
            state   <= ST_CRD0;
          end else begin
            dneg  <= dv[38];
            amag  <= dmag[37:8];
            state <= ST_LN2;
          end
        end
        ST_LN2:   state <= ST_LSET;
        ST_LSET: begin
          if (scale_mode) begin
            l     <= prod[59:30];
            state <= ST_SCMUL;
          end else begin
            nq    <= {9'b0, prod[59:30], 23'b0};
            dvs   <= dd;
            rem   <= '0;
            cnt   <= '0;
            state <= ST_DIVQ;
          end
        end
        ST_SCMUL: state <= ST_SCSET;
        ST_SCSET: begin
          nq    <= {9'b0, prod[59:30], 23'b0};
          dvs   <= dd;
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIVQ;
        end
        ST_DIVQ: begin
          rem <= rem_nx[dho_pkg::DIV_W-1:0];
          nq  <= {nq[dho_pkg::DIV_N-2:0], q_bit};
          cnt <= cnt + 1'b1;
          if (cnt == dho_pkg::CNT_W'(dho_pkg::DIV_N - 1)) state <= ST_QAMP;
        end
        ST_QAMP:  state <= ST_FIN;
        ST_FIN: begin
          res   <= rsat;
          phase <= pn;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hand over once the output register is free
          if (!out_valid || out_ready) begin
            sample_out <= res;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/decaying_harmonics_oscillator_core_tb.sv -----
// ----------------------------------------------------------------------------
// decaying_harmonics_oscillator_core_tb
// Self-checking bench for the oscillator core. A short table of directed
// requests is followed by random phases, each under its own register setting.
// Every accepted request is run through a bit-true model of the sample
// arithmetic. Each returned sample is checked against the oldest pending one.
// ----------------------------------------------------------------------------
module decaying_harmonics_oscillator_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          QDEPTH     = 1024;    // steps per quarter wave
  localparam logic [2:0]  REG_UNUSED = 3'd7;    // no register behind it
  localparam int          N_PHASES   = 8;
  localparam int          PHASE_REQS = 145;
  localparam longint      Q_CLAMP    = 64'd1 << 40;
  localparam logic [63:0] M_ONE      = 64'd1 << 30;

  // DUT ports
  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [30:0]        freq_sample;
  logic [15:0]        bright_sample;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] sample_out;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [30:0]        cfg_data;

  decaying_harmonics_oscillator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .freq_sample(freq_sample), .bright_sample(bright_sample),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Mirror of the block: register copies and the running phase
  logic [63:0]        quarter_cos [0:QDEPTH];
  logic signed [15:0] m_offset;
  logic signed [15:0] m_amp;
  logic               m_scale;
  logic               m_freq_stream;
  logic [30:0]        m_fixed_freq;
  logic               m_bright_stream;
  logic [15:0]        m_fixed_bright;
  logic [31:0]        m_phase;

  logic signed [15:0] pending_samples [$];
  int                 n_errors;
  int                 n_requests;
  int                 n_samples;
  int                 n_zero_freq;
  int                 n_saturated;
  bit                 calm;              // no idling on either side

  // Quarter-wave cosine, Q1.30, by a 12-term series
  function automatic void fill_quarter_cos();
    logic [63:0]        x, x2, term;
    longint             acc;
    for (int i = 0; i <= QDEPTH; i++) begin
      x    = (64'd1686629713 * 64'(i)) / 64'(QDEPTH);
      x2   = (x * x) >> 30;
      term = M_ONE;
      acc  = longint'(M_ONE);
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        if (k % 2) acc -= longint'(term);
        else       acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(M_ONE)) acc = longint'(M_ONE);
      quarter_cos[i] = 64'(acc);
    end
  endfunction

  function automatic logic [63:0] blend(logic [63:0] a, logic [63:0] b,
                                        logic [63:0] f16);
    return (a * (64'd65536 - f16) + b * f16) >> 16;
  endfunction

  // cos(2 pi p) in Q1.30 from the table, quadrant folded
  function automatic longint cos_of_phase(logic [31:0] p);
    logic [63:0] v, idx, f16, i, j;
    logic [1:0]  quad;
    v    = 64'(p) * 64'(4 * QDEPTH);
    idx  = v >> 32;
    f16  = (v & 64'hFFFF_FFFF) >> 16;
    quad = 2'((idx / QDEPTH) & 3);
    i    = idx % QDEPTH;
    j    = QDEPTH - i;
    case (quad)
      2'd0:    return  longint'(blend(quarter_cos[i], quarter_cos[i + 1], f16));
      2'd1:    return -longint'(blend(quarter_cos[j], quarter_cos[j - 1], f16));
      2'd2:    return -longint'(blend(quarter_cos[i], quarter_cos[i + 1], f16));
      default: return  longint'(blend(quarter_cos[j], quarter_cos[j - 1], f16));
    endcase
  endfunction

  // log2(x * 2^-30), Q.32, normalise then square-and-compare
  function automatic longint log2_fix(logic [63:0] x);
    logic [63:0] y, frac;
    int          n;
    if (x == 0) x = 1;
    n = 63;
    while (n > 0 && !x[n]) n--;
    y    = (n > 30) ? (x >> (n - 30)) : (x << (30 - n));
    frac = 0;
    for (int k = 1; k <= 16; k++) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y >>= 1;
        frac |= 64'd1 << (32 - k);
      end
    end
    return longint'(n - 30) * 64'sd4294967296 + longint'(frac);
  endfunction

  function automatic logic [63:0] one_minus_c_cos(logic [63:0] c, logic [31:0] p);
    longint      cs;
    logic [63:0] pr;
    cs = cos_of_phase(p);
    pr = (c * 64'(cs < 0 ? -cs : cs)) >> 30;
    return (cs < 0) ? M_ONE + pr : M_ONE - pr;
  endfunction

  // Next sample for one request; advances the mirrored phase
  function automatic logic signed [15:0] next_sample(logic [30:0] fin,
                                                     logic [15:0] bin);
    logic [63:0] f, b, m, m2, c, a, l, fm, dd, q, prod;
    logic [31:0] pn;
    longint      d, r, amp;
    bit          neg, aneg;
    f = m_freq_stream   ? 64'(fin) : 64'(m_fixed_freq);
    b = m_bright_stream ? 64'(bin) : 64'(m_fixed_bright);
    if (f == 0) begin
      m_phase = '0;
      n_zero_freq++;
      return m_offset;
    end
    m  = ((b * (m_scale ? 64'd1069129368 : 64'd1073676288)) >> 16) + 64'd32768;
    m2 = (m * m) >> 30;
    c  = ((2 * m) << 30) / (M_ONE + m2);
    pn = m_phase + 32'(f);
    d  = log2_fix(one_minus_c_cos(c, pn)) - log2_fix(one_minus_c_cos(c, m_phase));
    neg = d < 0;
    a   = 64'(neg ? -d : d) >> 8;
    l   = (a * 64'd744261118) >> 30;
    if (m_scale) l = (l * (M_ONE - m2)) >> 30;
    fm = (f * m) >> 30;
    dd = (fm * 64'd3373259426) >> 28;
    if (dd == 0) dd = 1;                 // tiny frequency: one LSB
    q = (l << 23) / dd;
    if (q > Q_CLAMP) q = Q_CLAMP;        // huge quotient clamp
    amp  = longint'(m_amp);
    aneg = amp < 0;
    prod = (q * 64'(aneg ? -amp : amp)) >> 12;
    r    = (neg != aneg) ? -longint'(prod) : longint'(prod);
    r   += longint'(m_offset);
    m_phase = pn;
    if (r > 32767 || r < -32768) n_saturated++;
    if (r > 32767)  r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: register mirror, request prediction, sample checking
  always @(posedge clk) begin
    if (rst) begin
      m_offset        <= 16'sd0;
      m_amp           <= 16'sd4096;
      m_scale         <= 1'b0;
      m_freq_stream   <= 1'b1;
      m_fixed_freq    <= '0;
      m_bright_stream <= 1'b0;
      m_fixed_bright  <= 16'd32768;
      m_phase         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          dho_pkg::REG_OFFSET_LEVEL:       m_offset        <= cfg_data[15:0];
          dho_pkg::REG_AMPLITUDE:          m_amp           <= cfg_data[15:0];
          dho_pkg::REG_SCALE_MODE:         m_scale         <= cfg_data[0];
          dho_pkg::REG_FREQ_FROM_STREAM:   m_freq_stream   <= cfg_data[0];
          dho_pkg::REG_FIXED_FREQ:         m_fixed_freq    <= cfg_data;
          dho_pkg::REG_BRIGHT_FROM_STREAM: m_bright_stream <= cfg_data[0];
          dho_pkg::REG_FIXED_BRIGHT:       m_fixed_bright  <= cfg_data[15:0];
          default: ;              // unused index, dropped
        endcase
      end
      if (in_valid && in_ready) begin
        pending_samples.push_back(next_sample(freq_sample, bright_sample));
        n_requests++;
      end
      if (out_valid && out_ready) begin
        n_samples++;
        if (pending_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %0d",
                   $time, sample_out);
          n_errors++;
        end else begin
          if (sample_out !== pending_samples[0]) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, pending_samples[0], sample_out);
            n_errors++;
          end
          void'(pending_samples.pop_front());
        end
      end
    end
  end

  // Receiver back-pressure: random stall and run bursts
  always @(negedge clk) begin : rx_pace
    int left;
    if (rst || calm) begin
      out_ready <= 1'b1;
      left = 0;
    end else if (left > 0) begin
      left--;
    end else begin
      out_ready <= $urandom_range(0, 2) != 0;
      left = $urandom_range(1, 19);
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
  endtask

  task automatic reg_write_done();
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0) @(posedge clk);
  endtask

  // One request; payload held until accepted. Called at a falling edge.
  task automatic send_request(logic [30:0] f, logic [15:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid      = 1'b1;
    freq_sample   = f;
    bright_sample = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Mostly musical frequencies, some full-range, some zero
  function automatic logic [30:0] pick_freq();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return 31'($urandom);
      3:       return 31'($urandom_range(1, 64));
      default: return 31'($urandom >> $urandom_range(8, 22));
    endcase
  endfunction

  typedef struct {
    logic [30:0]        f;
    logic [15:0]        b;
    bit                 known;
    logic signed [15:0] want;
  } stim_row_t;

  // Directed rows, brightness taken from the stream
  stim_row_t directed [] = '{
    '{31'd0,          16'd0,     1'b1, 16'sd0},  // silence gives offset
    '{31'h7FFF_FFFF,  16'hFFFF,  1'b0, 16'sd0},  // both at the top
    '{31'd1,          16'd0,     1'b0, 16'sd0},  // tiny f, quotient clamp
    '{31'd1,          16'hFFFF,  1'b0, 16'sd0},
    '{31'd0,          16'hFFFF,  1'b1, 16'sd0},  // phase cleared again
    '{31'h4000_0000,  16'd32768, 1'b0, 16'sd0},  // quarter cycle steps
    '{31'h4000_0000,  16'd32768, 1'b0, 16'sd0},
    '{31'h4000_0000,  16'd32768, 1'b0, 16'sd0},
    '{31'h4000_0000,  16'd32768, 1'b0, 16'sd0},
    '{31'h0100_0000,  16'd0,     1'b0, 16'sd0},
    '{31'h0100_0000,  16'd1,     1'b0, 16'sd0},
    '{31'h0010_0000,  16'hF000,  1'b0, 16'sd0},
    '{31'h0000_1000,  16'h8000,  1'b0, 16'sd0},
    '{31'h5555_5555,  16'h5555,  1'b0, 16'sd0},
    '{31'h2AAA_AAAA,  16'hAAAA,  1'b0, 16'sd0},
    '{31'd0,          16'd0,     1'b1, 16'sd0}
  };

  initial begin : main
    logic [63:0] lat;
    in_valid      = 1'b0;
    freq_sample   = '0;
    bright_sample = '0;
    cfg_write     = 1'b0;
    cfg_index     = dho_pkg::REG_OFFSET_LEVEL;
    cfg_data      = '0;
    calm          = 1'b0;
    n_errors      = 0;
    n_requests    = 0;
    n_samples     = 0;
    n_zero_freq   = 0;
    n_saturated   = 0;
    fill_quarter_cos();
    rst = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part: defaults apart from streamed brightness
    reg_write(dho_pkg::REG_BRIGHT_FROM_STREAM, 31'd1);
    reg_write_done();
    foreach (directed[i]) begin
      send_request(directed[i].f, directed[i].b);
      if (directed[i].known) begin
        // typed-in value must agree with the predictor before it is trusted
        if (pending_samples[$] !== directed[i].want) begin
          $display("%0t: table row %0d, expected %0d, actual %0d",
                   $time, i, directed[i].want, pending_samples[$]);
          n_errors++;
        end
      end
    end

    // random phases, each under a fresh register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      @(negedge clk);
      case (ph)
        0: begin                          // low extremes, amplitude at its positive top
          reg_write(dho_pkg::REG_OFFSET_LEVEL,       31'h0000_8000);
          reg_write(dho_pkg::REG_AMPLITUDE,          31'h0000_7FFF);
          reg_write(dho_pkg::REG_SCALE_MODE,         31'd0);
          reg_write(dho_pkg::REG_FREQ_FROM_STREAM,   31'd1);
          reg_write(dho_pkg::REG_FIXED_FREQ,         31'd0);
          reg_write(dho_pkg::REG_BRIGHT_FROM_STREAM, 31'd1);
          reg_write(dho_pkg::REG_FIXED_BRIGHT,       31'd0);
        end
        1: begin                          // high extremes, register sources
          reg_write(dho_pkg::REG_OFFSET_LEVEL,       31'h7FFF_7FFF);
          reg_write(dho_pkg::REG_AMPLITUDE,          31'h0000_8000);
          reg_write(dho_pkg::REG_SCALE_MODE,         31'h7FFF_FFFF);
          reg_write(dho_pkg::REG_FREQ_FROM_STREAM,   31'd0);
          reg_write(dho_pkg::REG_FIXED_FREQ,         31'h7FFF_FFFF);
          reg_write(dho_pkg::REG_BRIGHT_FROM_STREAM, 31'h7FFF_FFFE);
          reg_write(dho_pkg::REG_FIXED_BRIGHT,       31'h0000_FFFF);
        end
        default: begin
          reg_write(dho_pkg::REG_OFFSET_LEVEL,
                    31'($urandom) >> $urandom_range(0, 8));
          reg_write(dho_pkg::REG_AMPLITUDE,          31'($urandom));
          reg_write(dho_pkg::REG_SCALE_MODE,         31'($urandom));
          reg_write(dho_pkg::REG_FREQ_FROM_STREAM,   31'($urandom_range(0, 3) != 0));
          reg_write(dho_pkg::REG_FIXED_FREQ,
                    31'($urandom >> $urandom_range(1, 20)));
          reg_write(dho_pkg::REG_BRIGHT_FROM_STREAM, 31'($urandom_range(0, 1)));
          reg_write(dho_pkg::REG_FIXED_BRIGHT,       31'($urandom));
        end
      endcase
      reg_write(REG_UNUSED, 31'($urandom));   // must leave every register alone
      reg_write_done();
      calm = (ph == N_PHASES - 1);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (ph == 2 && n == 40) begin
          wait_drained();                 // sender holds off until all is back
          @(negedge clk);
        end
        send_request(pick_freq(), 16'($urandom));
      end
    end

    // drain, then allow for any late extra sample
    wait_drained();
    lat = 300;
    repeat (lat) @(posedge clk);
    $display("Covered %0d requests and %0d samples over %0d register settings,",
             n_requests, n_samples, N_PHASES + 1);
    $display("  %0d silent requests, %0d saturated samples.",
             n_zero_freq, n_saturated);
    if (n_errors == 0 && pending_samples.size() == 0) begin
      $display("[decaying_harmonics_oscillator_core] OK");
    end else begin
      $display("[decaying_harmonics_oscillator_core] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("%0t: timeout, %0d samples still pending", $time,
             pending_samples.size());
    $display("[decaying_harmonics_oscillator_core] ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
src/dho_pkg.sv
src/decaying_harmonics_oscillator_core.sv
sim/decaying_harmonics_oscillator_core_tb.sv
